// ===== hw/rtl/alb_pkg.sv =====
// Package for the ambient light backlight smoother.
// Holds constants, command and state codes, and divider control types.
// No dependencies.
package alb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int LUX_HIGH  = 800;
    localparam int LUX_LOW   = 10;
    localparam int LUX_SPAN  = 790;
    localparam int LEVEL_DIV = 10;

    // (lux - low) * |max - min| fits PROD_W bits; the LUX_SPAN reciprocal is exact below that
    localparam int PROD_W     = 18;
    localparam int SPAN_SHIFT = 28;
    localparam int SPAN_RECIP = (1 << SPAN_SHIFT) / LUX_SPAN + 1;
    localparam int RECIP_W    = 19;

    localparam logic [1:0] REG_SENSOR_PRESENT = 2'd0;
    localparam logic [1:0] REG_MIN_BRIGHTNESS = 2'd1;
    localparam logic [1:0] REG_MAX_BRIGHTNESS = 2'd2;

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_OVERRIDE = 2'd1,
        CMD_SLEEP    = 2'd2,
        CMD_WAKE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV1,
        ST_LVL,
        ST_DIV2,
        ST_FRAC,
        ST_DIV3,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic span;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/alb_div.sv =====
// Reciprocal multiply unit: quotient by LUX_SPAN or by LEVEL_DIV, one pass each.
// Operand registered at start, product taken the next cycle, done pulses in the cycle after that.
// Depends on alb_pkg.
module alb_div import alb_pkg::*; #(
    parameter int NUM_W = (FRAC_BITS_DEF + 5 > PROD_W) ? FRAC_BITS_DEF + 5 : PROD_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] dividend,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quotient
);

    localparam int MUL_W     = (NUM_W > RECIP_W) ? NUM_W : RECIP_W;
    localparam int FULL_W    = NUM_W + MUL_W;
    localparam int TEN_SHIFT = NUM_W + 3;
    localparam logic [MUL_W-1:0] TEN_RECIP = MUL_W'((64'd1 << TEN_SHIFT) / LEVEL_DIV + 1);
    localparam logic [MUL_W-1:0] SPAN_MULT = MUL_W'(SPAN_RECIP);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic              span_reg, span_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [MUL_W-1:0]  recip;
    logic [FULL_W-1:0] full;

    assign recip = span_reg ? SPAN_MULT : TEN_RECIP;
    assign full  = FULL_W'(num_reg) * FULL_W'(recip);

    always_comb begin
        num_next  = num_reg;
        span_next = span_reg;
        quo_next  = quo_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (ctrl.start) begin
            num_next  = dividend;
            span_next = ctrl.span;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = span_reg ? NUM_W'(full >> SPAN_SHIFT) : NUM_W'(full >> TEN_SHIFT);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        span_reg <= span_next;
        quo_reg  <= quo_next;
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hw/rtl/ambient_light_backlight_smoother.sv =====
// Ambient light backlight smoother, top level; depends on alb_pkg and alb_div.
// From an input beat, override, sleep and wake pass through EXEC to OUT; a clamped sample
// goes through EXEC, LVL, DIV2, FRAC, DIV3 and OUT, a linear-range sample also through DIV1.
// Every sensor sample uses the shared reciprocal unit. One command at a time: a sample without
// sensor goes back to idle and gives no beat; a stalled result holds the block.
// Synchronous active-low reset: level and saved level 0, sensor absent, min 10, max 255.
module ambient_light_backlight_smoother import alb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // lux [15:0], override_value [31:16]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // duty [7:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int LEVEL_W = FRAC_BITS + 8;
    localparam int LOW_W   = FRAC_BITS + 5;
    localparam int NUM_W   = (LOW_W > PROD_W) ? LOW_W : PROD_W;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [15:0]        lux_reg;
    logic [15:0]        ov_reg;
    logic               sensor_reg;
    logic [7:0]         min_reg, max_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] saved_reg, saved_next;
    logic [7:0]         tgt_reg, tgt_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic [7:0]         quo_hi_reg, quo_hi_next;
    logic [3:0]         rem_hi_reg, rem_hi_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_duty_reg, m_duty_next;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [NUM_W-1:0]   div_dividend;
    logic [NUM_W-1:0]   div_quotient;

    logic [8:0]         span_diff;
    logic [7:0]         span_mag;
    logic [15:0]        lux_off;
    logic [PROD_W-1:0]  prod;
    logic [9:0]         tgt_sum;
    logic [7:0]         ov_sat;
    logic [11:0]        lvl_acc;
    logic [11:0]        lvl_back;
    logic [11:0]        lvl_rem;
    logic [LOW_W-1:0]   low_sum;
    logic               out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign span_diff = {1'b0, max_reg} - {1'b0, min_reg};
    assign span_mag  = span_diff[8] ? 8'(-span_diff) : span_diff[7:0];
    assign lux_off   = lux_reg - 16'(LUX_LOW);
    assign prod      = PROD_W'(lux_off[9:0]) * PROD_W'(span_mag);

    assign tgt_sum = neg_reg ? ({2'b00, min_reg} - {2'b00, div_quotient[7:0]})
                             : ({2'b00, min_reg} + {2'b00, div_quotient[7:0]});

    // split 9 * level + target into whole and fraction parts
    assign lvl_acc  = 12'({level_reg[LEVEL_W-1:FRAC_BITS], 3'b000})
                    + 12'(level_reg[LEVEL_W-1:FRAC_BITS]) + 12'(tgt_reg);
    assign lvl_back = 12'({div_quotient[7:0], 3'b000}) + 12'({div_quotient[7:0], 1'b0});
    assign lvl_rem  = lvl_acc - lvl_back;
    assign low_sum  = {1'b0, rem_hi_reg, {FRAC_BITS{1'b0}}}
                    + LOW_W'({level_reg[FRAC_BITS-1:0], 3'b000})
                    + LOW_W'(level_reg[FRAC_BITS-1:0]);

    always_comb begin
        if (ov_reg[15]) begin
            ov_sat = 8'd0;
        end else if (ov_reg[14:8] != '0) begin
            ov_sat = 8'd255;
        end else begin
            ov_sat = ov_reg[7:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_reg == CMD_SAMPLE) begin
                    if (!sensor_reg) begin
                        state_next = ST_IDLE;
                    end else if (lux_reg > 16'(LUX_HIGH) || lux_reg < 16'(LUX_LOW)) begin
                        state_next = ST_LVL;
                    end else begin
                        state_next = ST_DIV1;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV1: begin
                if (div_stat.done) begin
                    state_next = ST_LVL;
                end
            end
            ST_LVL: state_next = ST_DIV2;
            ST_DIV2: begin
                if (div_stat.done) begin
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: state_next = ST_DIV3;
            ST_DIV3: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        level_next     = level_reg;
        saved_next     = saved_reg;
        tgt_next       = tgt_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        quo_hi_next    = quo_hi_reg;
        rem_hi_next    = rem_hi_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_duty_next    = m_duty_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.span  = 1'b0;
        div_dividend   = NUM_W'(prod);
        case (state_reg)
            ST_EXEC: begin
                zero_next = 1'b0;
                case (cmd_reg)
                    CMD_SAMPLE: begin
                        neg_next = span_diff[8];
                        if (lux_reg > 16'(LUX_HIGH)) begin
                            tgt_next = max_reg;
                        end else if (lux_reg < 16'(LUX_LOW)) begin
                            tgt_next = min_reg;
                        end else begin
                            div_ctrl.start = sensor_reg;
                            div_ctrl.span  = 1'b1;
                        end
                    end
                    CMD_OVERRIDE: level_next = {ov_sat, {FRAC_BITS{1'b0}}};
                    CMD_SLEEP: begin
                        saved_next = level_reg;
                        zero_next  = 1'b1;
                    end
                    CMD_WAKE: level_next = saved_reg;
                    default: level_next = level_reg;
                endcase
            end
            ST_DIV1: begin
                if (div_stat.done) begin
                    if (tgt_sum[9]) begin
                        tgt_next = 8'd0;
                    end else if (tgt_sum[8]) begin
                        tgt_next = 8'd255;
                    end else begin
                        tgt_next = tgt_sum[7:0];
                    end
                end
            end
            ST_LVL: begin
                div_ctrl.start = 1'b1;
                div_dividend   = NUM_W'(lvl_acc);
            end
            ST_DIV2: begin
                if (div_stat.done) begin
                    quo_hi_next = div_quotient[7:0];
                    rem_hi_next = lvl_rem[3:0];
                end
            end
            ST_FRAC: begin
                div_ctrl.start = 1'b1;
                div_dividend   = NUM_W'(low_sum);
            end
            ST_DIV3: begin
                if (div_stat.done) begin
                    level_next = {quo_hi_reg, {FRAC_BITS{1'b0}}} + LEVEL_W'(div_quotient);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_duty_next  = zero_reg ? 8'd0 : level_reg[LEVEL_W-1:FRAC_BITS];
                end
            end
            default: m_duty_next = m_duty_reg;
        endcase
    end

    alb_div #(
        .NUM_W(NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sensor_reg  <= 1'b0;
            min_reg     <= 8'd10;
            max_reg     <= 8'd255;
            level_reg   <= '0;
            saved_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            saved_reg   <= saved_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SENSOR_PRESENT: sensor_reg <= cfg_data[0];
                    REG_MIN_BRIGHTNESS: min_reg    <= cfg_data;
                    REG_MAX_BRIGHTNESS: max_reg    <= cfg_data;
                    default: sensor_reg <= sensor_reg;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_t'(s_tuser);
            lux_reg <= s_tdata[15:0];
            ov_reg  <= s_tdata[31:16];
        end
        tgt_reg    <= tgt_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        quo_hi_reg <= quo_hi_next;
        rem_hi_reg <= rem_hi_next;
        m_duty_reg <= m_duty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_duty_reg;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for ambient_light_backlight_smoother: directed and random command
// streams checked beat by beat against a built-in model of the smoothing filter.
// Depends on alb_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
    import alb_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int SETTLE   = 64;
    localparam int HOLD_AT  = 700;
    localparam int HOLD_LEN = 400;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] lux;
        logic [15:0] ov;
    } command_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    command_t   cmd_pending[$];
    logic [7:0] duty_expected[$];

    logic        sensor_on = 1'b0;
    logic [7:0]  min_b = 8'd10;
    logic [7:0]  max_b = 8'd255;
    logic [23:0] level_q = '0;
    logic [23:0] saved_q = '0;

    logic s_beat = 1'b0;
    int   idle_pct = 38;
    int   items_pushed = 0;
    int   items_taken = 0;
    int   cfg_beats = 0;
    int   mismatches = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    ambient_light_backlight_smoother #(
        .FRAC_BITS(FRAC)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),      // lux [15:0], override_value [31:16]
        .s_tuser(s_tuser),      // cmd [1:0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),      // duty [7:0]
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic logic [7:0] lux_target(logic [15:0] lux);
        int l;
        int lo;
        int hi;
        int t;
        l = lux;
        lo = min_b;
        hi = max_b;
        if (l > LUX_HIGH) return max_b;
        if (l < LUX_LOW) return min_b;
        t = lo + ((l - LUX_LOW) * (hi - lo)) / LUX_SPAN;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
    endfunction

    function automatic logic [7:0] level_duty(logic [23:0] lv);
        logic [23:0] whole;
        whole = lv >> FRAC;
        return (whole > 24'd255) ? 8'd255 : whole[7:0];
    endfunction

    task automatic smooth_step(input cmd_t cmd, input logic [15:0] lux,
                               input logic [15:0] ov, output bit has_duty,
                               output logic [7:0] duty);
        longint unsigned acc;
        longint unsigned tgt;
        logic [7:0]      sat;
        has_duty = 1'b1;
        duty = '0;
        case (cmd)
            CMD_SAMPLE: begin
                if (!sensor_on) begin
                    has_duty = 1'b0;
                end else begin
                    tgt = lux_target(lux);
                    acc = 9 * longint'(level_q) + (tgt << FRAC);
                    level_q = 24'(acc / LEVEL_DIV);
                    duty = level_duty(level_q);
                end
            end
            CMD_OVERRIDE: begin
                if (ov[15]) sat = 8'd0;
                else if (ov > 16'd255) sat = 8'd255;
                else sat = ov[7:0];
                level_q = 24'(sat) << FRAC;
                duty = level_duty(level_q);
            end
            CMD_SLEEP: begin
                saved_q = level_q;
            end
            default: begin
                level_q = saved_q;
                duty = level_duty(level_q);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        bit         has_duty;
        logic [7:0] duty;
        if (!aresetn) begin
            s_beat <= 1'b0;
        end else begin
            s_beat <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SENSOR_PRESENT: sensor_on = cfg_data[0];
                    REG_MIN_BRIGHTNESS: min_b = cfg_data;
                    REG_MAX_BRIGHTNESS: max_b = cfg_data;
                    default: ;
                endcase
                cfg_beats++;
            end
            if (s_tvalid && s_tready) begin
                smooth_step(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[31:16], has_duty, duty);
                if (has_duty) duty_expected.push_back(duty);
                void'(cmd_pending.pop_front());
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (duty_expected.size() == 0) begin
                    $error("duty: expected none, actual %0d", m_tdata);
                    mismatches++;
                end else begin
                    duty = duty_expected.pop_front();
                    if (m_tdata !== duty) begin
                        $error("duty: expected %0d, actual %0d", duty, m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {cmd_pending[0].ov, cmd_pending[0].lux};
                s_tuser  <= cmd_pending[0].cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= idle_pct;
        end
    end

    task automatic push_cmd(input cmd_t cmd, input logic [15:0] lux, input logic [15:0] ov);
        command_t c;
        c.cmd = cmd;
        c.lux = lux;
        c.ov = ov;
        cmd_pending.push_back(c);
        items_pushed++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        int n;
        n = cfg_beats;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        wait (cfg_beats != n);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (items_taken != items_pushed || duty_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_random();
        cmd_t        cmd;
        logic [15:0] lux;
        logic [15:0] ov;
        int          r;
        r = $urandom_range(99);
        if (r < 60) cmd = CMD_SAMPLE;
        else if (r < 75) cmd = CMD_OVERRIDE;
        else if (r < 87) cmd = CMD_SLEEP;
        else cmd = CMD_WAKE;
        case ($urandom_range(4))
            0: lux = 16'($urandom_range(9));
            1: lux = 16'($urandom_range(10, 800));
            2: lux = 16'($urandom_range(801, 2000));
            3: lux = 16'($urandom_range(795, 805));
            default: lux = 16'($urandom);
        endcase
        case ($urandom_range(2))
            0: ov = 16'($urandom_range(255));
            1: ov = 16'($urandom_range(250, 260));
            default: ov = 16'($urandom);
        endcase
        push_cmd(cmd, lux, ov);
    endtask

    task automatic run_setting(input bit present, input logic [7:0] lo, input logic [7:0] hi,
                               input int n, input int idle);
        idle_pct = idle;
        write_reg(REG_SENSOR_PRESENT, {7'd0, present});
        write_reg(REG_MIN_BRIGHTNESS, lo);
        write_reg(REG_MAX_BRIGHTNESS, hi);
        repeat (n) push_random();
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: no sensor, so samples drop
        push_cmd(CMD_WAKE, 16'd0, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd500, 16'd0);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'd300);
        push_cmd(CMD_SLEEP, 16'd0, 16'd0);
        drain();

        write_reg(REG_SENSOR_PRESENT, 8'd1);
        write_reg(REG_MIN_BRIGHTNESS, 8'd0);
        write_reg(REG_MAX_BRIGHTNESS, 8'd255);
        push_cmd(CMD_SAMPLE, 16'd0, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd9, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd10, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd11, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd800, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd801, 16'd0);
        push_cmd(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'h8000);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'hFFFF);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'd256);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'h7FFF);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'd0);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'd255);
        push_cmd(CMD_SLEEP, 16'd0, 16'd0);
        push_cmd(CMD_OVERRIDE, 16'd0, 16'd40);
        push_cmd(CMD_SLEEP, 16'd0, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd400, 16'd0);
        push_cmd(CMD_WAKE, 16'd0, 16'd0);
        drain();

        // falling map
        write_reg(REG_MIN_BRIGHTNESS, 8'd255);
        write_reg(REG_MAX_BRIGHTNESS, 8'd0);
        push_cmd(CMD_SAMPLE, 16'd10, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd405, 16'd0);
        push_cmd(CMD_SAMPLE, 16'd800, 16'd0);
        drain();

        run_setting(1'b1, 8'd0, 8'd255, 150, 38);
        run_setting(1'b1, 8'd255, 8'd0, 150, 38);
        run_setting(1'b1, 8'd10, 8'd255, 200, 0);
        run_setting(1'b0, 8'd10, 8'd255, 80, 38);
        run_setting(1'b1, 8'd0, 8'd0, 100, 38);
        run_setting(1'b1, 8'd255, 8'd255, 120, 38);
        repeat (4) begin
            run_setting(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)), 110, 38);
        end

        if (mismatches == 0 && duty_expected.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
